@@ src/tdma_beacon_slot_scheduler_macros.svh @@
// assertion helpers for the checker file
`ifndef TDMA_BEACON_SLOT_SCHEDULER_MACROS_SVH
`define TDMA_BEACON_SLOT_SCHEDULER_MACROS_SVH

// same-cycle implication, off while reset is held
`define TBSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is held
`define TBSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/tbss_pkg.sv @@
package tbss_pkg;

  localparam int TIME_W  = 64;
  localparam int FRAME_W = 32;
  localparam int DELAY_W = 25;
  localparam int CFG_W   = 5;
  localparam int ACT_W   = 2;

  localparam int IN_TDATA_W  = 152;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 128;
  localparam int OUT_TUSER_W = 3;

  // frame layout in ms
  localparam int MS_NS            = 1_000_000;
  localparam int BEACON_WINDOW_MS = 20;
  localparam int GUARD1_MS        = 4;
  localparam int SLOT_MS          = 4;
  localparam int HALF_SLOT_MS     = 2;
  localparam int GUARD2_MS        = 12;

  localparam logic [DELAY_W-1:0] MAX_DELAY_NS = DELAY_W'(BEACON_WINDOW_MS * MS_NS);

  localparam int MID_W = 32;

  localparam logic [ACT_W-1:0] ACT_NONE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_BEACON = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SLOT   = 2'd2;

  typedef struct packed {
    logic               func;
    logic [TIME_W-1:0]  now_ns;
    logic               beacon_ok;
    logic [FRAME_W-1:0] rx_frame;
    logic [DELAY_W-1:0] rx_delay_ns;
    logic [DELAY_W-1:0] random_delay_ns;
  } item_t;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic               timer_armed;
    logic [TIME_W-1:0]  deadline_ns;
    logic [FRAME_W-1:0] tx_frame;
    logic [DELAY_W-1:0] tx_delay_ns;
  } res_t;

endpackage

@@ src/tdma_beacon_slot_scheduler.sv @@
// slot scheduler for a beacon-synchronised tdma station: each input transaction
// is a timer expiry (tuser bit 0 low) or a received message (tuser bit 0 high,
// bit 1 marks a good beacon); each one yields exactly one output transaction
// with the action to take (none, send beacon, send own slot message) and, when
// armed, the next absolute timer deadline in ns. frames are
// 36 + 4*SLOT_COUNT ms long: 20 ms beacon window, 4 ms guard, SLOT_COUNT slots
// of 4 ms, 12 ms guard; the own slot fires in the middle of its slot. delays
// above 20 ms are saturated, slot_index 0 acts as slot 1 and values above
// SLOT_COUNT as the last slot. the first timer after start-up is armed by the
// host. a transaction passes the input register, then one pass through the
// scheduling logic into the result register, and a new one is taken every cycle
// while the output is not stalled; the scheduling pass, with its single constant
// multiply of the frame counter, sets the clock limit. the host must make cfg
// writes only while the block is idle; the block itself does not enforce this
module tdma_beacon_slot_scheduler #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // slot index configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tbss_pkg::CFG_W-1:0]       cfg_data,     // slot_index
  // event input
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // now_ns[63:0], rx_frame[95:64], rx_delay_ns[120:96],
  // random_delay_ns[145:121], zero pad above
  input  logic [tbss_pkg::IN_TDATA_W-1:0]  in_tdata,
  // func[0], beacon_ok[1]
  input  logic [tbss_pkg::IN_TUSER_W-1:0]  in_tuser,
  // scheduling result
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // deadline_ns[63:0], tx_frame[95:64], tx_delay_ns[120:96], zero pad above
  output logic [tbss_pkg::OUT_TDATA_W-1:0] out_tdata,
  // action[1:0], timer_armed[2]
  output logic [tbss_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import tbss_pkg::*;

  localparam int MID_BASE_NS = (BEACON_WINDOW_MS + GUARD1_MS - HALF_SLOT_MS) * MS_NS;
  localparam int SLOT_NS     = SLOT_MS * MS_NS;
  localparam int SLOT_SEL_W  = $clog2(SLOT_COUNT + 1) + 1;

  logic [MID_W-1:0]      mid_r, mid_nxt;
  logic [SLOT_SEL_W-1:0] slot_sel;
  logic                  item_valid;
  logic                  item_ready;
  item_t                 item;
  res_t                  res;

  // own slot mid-point offset from frame start, worked out once per cfg write
  always_comb begin
    if (cfg_data == '0) begin
      slot_sel = SLOT_SEL_W'(1);
    end else if (SLOT_SEL_W'(cfg_data) > SLOT_SEL_W'(SLOT_COUNT)) begin
      slot_sel = SLOT_SEL_W'(SLOT_COUNT);
    end else begin
      slot_sel = SLOT_SEL_W'(cfg_data);
    end
    mid_nxt = MID_W'(MID_BASE_NS) + MID_W'(slot_sel) * MID_W'(SLOT_NS);
  end

  assign cfg_ready = 1'b1;

  // reset value is slot 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= MID_W'(MID_BASE_NS + SLOT_NS);
    end else if (cfg_valid && cfg_ready) begin
      mid_r <= mid_nxt;
    end
  end

  tbss_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .m_valid   (item_valid),
    .m_ready   (item_ready),
    .m_item    (item)
  );

  tbss_engine #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (item_valid),
    .s_ready (item_ready),
    .s_item  (item),
    .mid_ns  (mid_r),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_res   (res)
  );

  // result packing, zero pad on top
  assign out_tdata = {7'd0, res.tx_delay_ns, res.tx_frame, res.deadline_ns};
  assign out_tuser = {res.timer_armed, res.action};

endmodule

@@ src/tbss_in_reg.sv @@
module tbss_in_reg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tbss_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [tbss_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                             m_valid,
  input  logic                             m_ready,
  output tbss_pkg::item_t                  m_item
);
  import tbss_pkg::*;

  logic  vld_r;
  item_t item_r;
  item_t item_nxt;

  function automatic logic [DELAY_W-1:0] sat_delay(input logic [DELAY_W-1:0] d);
    return (d > MAX_DELAY_NS) ? MAX_DELAY_NS : d;
  endfunction

  assign in_tready = !vld_r || m_ready;

  always_comb begin
    item_nxt.func            = in_tuser[0];
    item_nxt.beacon_ok       = in_tuser[1];
    item_nxt.now_ns          = in_tdata[63:0];
    item_nxt.rx_frame        = in_tdata[95:64];
    item_nxt.rx_delay_ns     = sat_delay(in_tdata[120:96]);
    item_nxt.random_delay_ns = sat_delay(in_tdata[145:121]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
  end

  assign m_valid = vld_r;
  assign m_item  = item_r;

endmodule

@@ src/tbss_engine.sv @@
module tbss_engine #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         s_valid,
  output logic                         s_ready,
  input  tbss_pkg::item_t              s_item,
  input  logic [tbss_pkg::MID_W-1:0]   mid_ns,
  output logic                         m_valid,
  input  logic                         m_ready,
  output tbss_pkg::res_t               m_res
);
  import tbss_pkg::*;

  typedef enum logic [1:0] {PH_INIT, PH_WAIT_BEACON, PH_WAIT_SLOT} phase_t;

  localparam int FRAME_MS   = BEACON_WINDOW_MS + GUARD1_MS + SLOT_COUNT * SLOT_MS + GUARD2_MS;
  localparam int FRAME_NS_W = $clog2(FRAME_MS * MS_NS + 1);
  localparam logic [FRAME_NS_W-1:0] FRAME_NS_K = FRAME_NS_W'(FRAME_MS * MS_NS);

  phase_t             phase_r, phase_nxt;
  logic [TIME_W-1:0]  frame_start_r, frame_start_nxt;
  logic [TIME_W-1:0]  time_offset_r, time_offset_nxt;
  logic [FRAME_W-1:0] frame_count_r, frame_count_nxt;
  logic [DELAY_W-1:0] beacon_delay_r, beacon_delay_nxt;
  logic               out_valid_r;
  res_t               res_r, res_nxt;

  logic               timer;
  logic               advance;
  logic [FRAME_W-1:0] fc_inc;
  logic [FRAME_W-1:0] fc_mul;
  logic [TIME_W-1:0]  prod;
  logic [TIME_W-1:0]  cand;
  logic [TIME_W-1:0]  init_fs;
  logic [TIME_W-1:0]  keep_fs;
  logic [TIME_W-1:0]  keep_dl;
  logic [TIME_W-1:0]  new_dl;
  logic               take_new;

  assign s_ready = !out_valid_r || m_ready;
  assign advance = s_valid && s_ready;

  always_comb begin
    timer   = !s_item.func;
    fc_inc  = frame_count_r + 32'd1;
    // one constant multiplier serves both the own-beacon and the adopt path
    fc_mul  = (phase_r == PH_WAIT_BEACON && timer) ? fc_inc : s_item.rx_frame;
    prod    = 64'(fc_mul) * 64'(FRAME_NS_K);
    // frame start from the beacon itself; the offset it implies is cand
    init_fs  = s_item.now_ns - 64'(s_item.rx_delay_ns);
    cand     = init_fs - prod;
    keep_fs  = prod + time_offset_r;
    take_new = cand < time_offset_r;
    // both deadline candidates in parallel, the offset compare only selects
    keep_dl  = keep_fs + 64'(mid_ns);
    new_dl   = init_fs + 64'(mid_ns);

    phase_nxt        = phase_r;
    frame_start_nxt  = frame_start_r;
    time_offset_nxt  = time_offset_r;
    frame_count_nxt  = frame_count_r;
    beacon_delay_nxt = beacon_delay_r;
    res_nxt          = '0;
    res_nxt.action   = ACT_NONE;

    unique case (phase_r)
      PH_WAIT_SLOT: begin
        if (timer) begin
          res_nxt.action      = ACT_SLOT;
          beacon_delay_nxt    = s_item.random_delay_ns;
          res_nxt.deadline_ns = frame_start_r + 64'(FRAME_NS_K)
                                + 64'(s_item.random_delay_ns);
          res_nxt.timer_armed = 1'b1;
          phase_nxt           = PH_WAIT_BEACON;
        end
      end
      PH_WAIT_BEACON: begin
        if (timer) begin
          frame_count_nxt     = fc_inc;
          res_nxt.action      = ACT_BEACON;
          res_nxt.tx_frame    = fc_inc;
          res_nxt.tx_delay_ns = beacon_delay_r;
          frame_start_nxt     = keep_fs;
          res_nxt.deadline_ns = keep_dl;
          res_nxt.timer_armed = 1'b1;
          phase_nxt           = PH_WAIT_SLOT;
        end else if (s_item.beacon_ok) begin
          frame_count_nxt     = s_item.rx_frame;
          beacon_delay_nxt    = s_item.rx_delay_ns;
          time_offset_nxt     = take_new ? cand : time_offset_r;
          frame_start_nxt     = take_new ? init_fs : keep_fs;
          res_nxt.deadline_ns = take_new ? new_dl : keep_dl;
          res_nxt.timer_armed = 1'b1;
          phase_nxt           = PH_WAIT_SLOT;
        end
      end
      default: begin
        if (timer) begin
          frame_start_nxt     = s_item.now_ns;
          time_offset_nxt     = s_item.now_ns;
          res_nxt.deadline_ns = s_item.now_ns + 64'(mid_ns);
          res_nxt.timer_armed = 1'b1;
          phase_nxt           = PH_WAIT_SLOT;
        end else if (s_item.beacon_ok) begin
          frame_count_nxt     = s_item.rx_frame;
          beacon_delay_nxt    = s_item.rx_delay_ns;
          frame_start_nxt     = init_fs;
          time_offset_nxt     = cand;
          res_nxt.deadline_ns = new_dl;
          res_nxt.timer_armed = 1'b1;
          phase_nxt           = PH_WAIT_SLOT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_INIT;
      frame_start_r  <= '0;
      time_offset_r  <= '0;
      frame_count_r  <= '0;
      beacon_delay_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (advance) begin
        phase_r        <= phase_nxt;
        frame_start_r  <= frame_start_nxt;
        time_offset_r  <= time_offset_nxt;
        frame_count_r  <= frame_count_nxt;
        beacon_delay_r <= beacon_delay_nxt;
        res_r          <= res_nxt;
        out_valid_r    <= 1'b1;
      end else if (m_ready) begin
        out_valid_r    <= 1'b0;
      end
    end
  end

  assign m_valid = out_valid_r;
  assign m_res   = res_r;

endmodule

@@ src/tbss_checker.sv @@
`include "tdma_beacon_slot_scheduler_macros.svh"

module tbss_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tbss_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [tbss_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import tbss_pkg::*;

  // stalled result holds
  `TBSS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  // no deadline unless armed
  `TBSS_ASSERT_NOW(a_deadline_zero, out_tvalid && !out_tuser[2], out_tdata[63:0] == 64'd0, "deadline set without timer armed")
  // any send action rearms the timer
  `TBSS_ASSERT_NOW(a_send_arms, out_tvalid && (out_tuser[1:0] == ACT_BEACON || out_tuser[1:0] == ACT_SLOT), out_tuser[2], "send action without new deadline")
  // beacon contents only with a beacon
  `TBSS_ASSERT_NOW(a_tx_zero, out_tvalid && out_tuser[1:0] != ACT_BEACON, out_tdata[120:64] == 57'd0, "beacon fields set without beacon action")

endmodule

bind tdma_beacon_slot_scheduler tbss_checker u_tbss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ tb/tdma_beacon_slot_scheduler_tb.sv @@
module tdma_beacon_slot_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbss_pkg::*;

  localparam int SLOT_COUNT   = 16;
  localparam int DRAIN_CYCLES = 8;   // two-stage pipe plus margin
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_EVENTS = 156; // about 1250 random events over all phases

  // frame is 100 ms with the default slot count
  localparam logic [TIME_W-1:0] FRAME_NS = TIME_W'(
      (BEACON_WINDOW_MS + GUARD1_MS + SLOT_COUNT * SLOT_MS + GUARD2_MS) * MS_NS);

  typedef enum logic [1:0] {
    SCHED_INIT,
    SCHED_WAIT_BEACON,
    SCHED_WAIT_SLOT
  } sched_phase_t;

  // ---------------------------------------------------------------------------
  // scheduler predictor and store of outstanding results
  // ---------------------------------------------------------------------------
  class slot_sched_scoreboard;
    logic [CFG_W-1:0]   slot_idx     = CFG_W'(1);
    sched_phase_t       phase        = SCHED_INIT;
    logic [TIME_W-1:0]  frame_start  = '0;
    logic [TIME_W-1:0]  time_offset  = '0;
    logic [FRAME_W-1:0] frame_cnt    = '0;
    logic [DELAY_W-1:0] beacon_dly   = '0;
    logic [TIME_W-1:0]  last_deadline = '0;
    res_t               due_results[$];
    int                 mismatches   = 0;

    function logic [DELAY_W-1:0] clamp_delay(logic [DELAY_W-1:0] d);
      return (d > MAX_DELAY_NS) ? MAX_DELAY_NS : d;
    endfunction

    // own slot fires half a slot into it, slot index clamped to 1..SLOT_COUNT
    function logic [TIME_W-1:0] mid_slot();
      logic [TIME_W-1:0] s;
      s = TIME_W'(slot_idx);
      if (s < 1) s = TIME_W'(1);
      if (s > SLOT_COUNT) s = TIME_W'(SLOT_COUNT);
      return (TIME_W'(BEACON_WINDOW_MS + GUARD1_MS - HALF_SLOT_MS) + TIME_W'(SLOT_MS) * s)
             * TIME_W'(MS_NS);
    endfunction

    function logic [TIME_W-1:0] frame_span(logic [FRAME_W-1:0] cnt);
      return TIME_W'(cnt) * FRAME_NS;
    endfunction

    // advance the scheduler by one event and queue the result it produces
    function void schedule_event(item_t ev);
      res_t               r;
      logic [DELAY_W-1:0] rxd;
      logic [DELAY_W-1:0] rnd;
      logic [TIME_W-1:0]  candidate;
      bit                 timer;
      r     = '0;
      timer = (ev.func == 1'b0);
      rxd   = clamp_delay(ev.rx_delay_ns);
      rnd   = clamp_delay(ev.random_delay_ns);
      case (phase)
        SCHED_WAIT_SLOT: begin
          // beacons are ignored here, only the slot timer counts
          if (timer) begin
            r.action      = ACT_SLOT;
            beacon_dly    = rnd;
            r.deadline_ns = frame_start + FRAME_NS + TIME_W'(beacon_dly);
            r.timer_armed = 1'b1;
            phase         = SCHED_WAIT_BEACON;
          end
        end
        SCHED_WAIT_BEACON: begin
          if (timer) begin
            // nobody else beaconed first, so send our own
            frame_cnt     = frame_cnt + 1'b1;
            r.action      = ACT_BEACON;
            r.tx_frame    = frame_cnt;
            r.tx_delay_ns = beacon_dly;
            frame_start   = frame_span(frame_cnt) + time_offset;
            r.deadline_ns = frame_start + mid_slot();
            r.timer_armed = 1'b1;
            phase         = SCHED_WAIT_SLOT;
          end else if (ev.beacon_ok) begin
            frame_cnt  = ev.rx_frame;
            beacon_dly = rxd;
            candidate  = ev.now_ns - frame_span(frame_cnt) - TIME_W'(beacon_dly);
            if (candidate < time_offset) time_offset = candidate;
            frame_start   = frame_span(frame_cnt) + time_offset;
            r.deadline_ns = frame_start + mid_slot();
            r.timer_armed = 1'b1;
            phase         = SCHED_WAIT_SLOT;
          end
        end
        default: begin
          if (timer) begin
            frame_start   = ev.now_ns;
            time_offset   = ev.now_ns;
            r.deadline_ns = frame_start + mid_slot();
            r.timer_armed = 1'b1;
            phase         = SCHED_WAIT_SLOT;
          end else if (ev.beacon_ok) begin
            frame_cnt     = ev.rx_frame;
            beacon_dly    = rxd;
            frame_start   = ev.now_ns - TIME_W'(beacon_dly);
            time_offset   = frame_start - frame_span(frame_cnt);
            r.deadline_ns = frame_start + mid_slot();
            r.timer_armed = 1'b1;
            phase         = SCHED_WAIT_SLOT;
          end
        end
      endcase
      if (r.timer_armed) last_deadline = r.deadline_ns;
      due_results.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t exp;
      if (due_results.size() == 0) begin
        $error("result with nothing outstanding: action %0d deadline %0d", got.action,
               got.deadline_ns);
        mismatches++;
        return;
      end
      exp = due_results.pop_front();
      if (got.action !== exp.action) begin
        $error("action: expected %0d, got %0d", exp.action, got.action);
        mismatches++;
      end
      if (got.timer_armed !== exp.timer_armed) begin
        $error("timer_armed: expected %0d, got %0d", exp.timer_armed, got.timer_armed);
        mismatches++;
      end
      if (got.deadline_ns !== exp.deadline_ns) begin
        $error("deadline_ns: expected %0d, got %0d", exp.deadline_ns, got.deadline_ns);
        mismatches++;
      end
      if (got.tx_frame !== exp.tx_frame) begin
        $error("tx_frame: expected %0d, got %0d", exp.tx_frame, got.tx_frame);
        mismatches++;
      end
      if (got.tx_delay_ns !== exp.tx_delay_ns) begin
        $error("tx_delay_ns: expected %0d, got %0d", exp.tx_delay_ns, got.tx_delay_ns);
        mismatches++;
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset and block
  // ---------------------------------------------------------------------------
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  int tx_idle_pct  = 0; // chance per cycle that the sender holds back
  int rx_stall_pct = 0; // chance per cycle that the receiver stalls

  slot_sched_scoreboard sb = new();

  always #4 clk = ~clk;

  tdma_beacon_slot_scheduler #(
    .SLOT_COUNT(SLOT_COUNT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // every completed output transaction is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result('{action:      out_tuser[1:0],
                        timer_armed: out_tuser[2],
                        deadline_ns: out_tdata[63:0],
                        tx_frame:    out_tdata[95:64],
                        tx_delay_ns: out_tdata[120:96]});
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic item_t make_item(logic fn, logic ok, logic [TIME_W-1:0] now,
                                      logic [FRAME_W-1:0] rxf, logic [DELAY_W-1:0] rxd,
                                      logic [DELAY_W-1:0] rnd);
    item_t ev;
    ev.func            = fn;
    ev.now_ns          = now;
    ev.beacon_ok       = ok;
    ev.rx_frame        = rxf;
    ev.rx_delay_ns     = rxd;
    ev.random_delay_ns = rnd;
    return ev;
  endfunction

  // mostly legal delays, now and then one that needs saturating
  function automatic logic [DELAY_W-1:0] draw_delay();
    if ($urandom_range(9) == 0) return DELAY_W'($urandom_range(0, 33554431));
    return DELAY_W'($urandom_range(0, 20_000_000));
  endfunction

  function automatic logic [TIME_W-1:0] draw_time();
    return {$urandom, $urandom};
  endfunction

  // next event, shaped after where the scheduler currently stands so that the
  // timer / beacon cycle keeps turning; a small share is pure noise
  function automatic item_t next_event();
    logic [DELAY_W-1:0] rxd;
    logic [FRAME_W-1:0] rxf;
    logic [TIME_W-1:0]  jitter;
    int                 pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      return make_item(1'($urandom_range(1)), 1'($urandom_range(1)), draw_time(), $urandom,
                       DELAY_W'($urandom_range(0, 33554431)),
                       DELAY_W'($urandom_range(0, 33554431)));
    end
    case (sb.phase)
      SCHED_WAIT_SLOT: begin
        if (pick < 90)
          return make_item(1'b0, 1'($urandom_range(1)), sb.last_deadline, $urandom,
                           draw_delay(), draw_delay());
        return make_item(1'b1, 1'($urandom_range(1)), draw_time(), $urandom, draw_delay(),
                         draw_delay());
      end
      SCHED_WAIT_BEACON: begin
        if (pick < 55)
          return make_item(1'b0, 1'($urandom_range(1)), sb.last_deadline, $urandom,
                           draw_delay(), draw_delay());
        if (pick < 95) begin
          // another station's beacon, roughly where it should land in the frame
          rxd    = draw_delay();
          rxf    = ($urandom_range(4) != 0) ? sb.frame_cnt + 1'b1 : FRAME_W'($urandom);
          jitter = TIME_W'($urandom_range(2_000_000));
          return make_item(1'b1, 1'b1,
                           sb.frame_start + FRAME_NS + TIME_W'(sb.clamp_delay(rxd))
                           + jitter - TIME_W'(1_000_000),
                           rxf, rxd, draw_delay());
        end
        return make_item(1'b1, 1'b0, draw_time(), $urandom, draw_delay(), draw_delay());
      end
      default:
        return make_item(1'($urandom_range(1)), 1'($urandom_range(1)), draw_time(), $urandom,
                         draw_delay(), draw_delay());
    endcase
  endfunction

  function automatic int draw_gap();
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    return gap;
  endfunction

  // one input transaction; the prediction is taken at the accepting edge
  task automatic send_event(item_t ev, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {6'b0, ev.random_delay_ns, ev.rx_delay_ns, ev.rx_frame, ev.now_ns};
    in_tuser  <= {ev.beacon_ok, ev.func};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.schedule_event(ev);
  endtask

  task automatic write_slot(logic [CFG_W-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.slot_idx = value;
  endtask

  // let every outstanding result come back before touching the config
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [CFG_W-1:0] slot_plan[RAND_PHASES];
    slot_plan = '{5'd16, 5'd31, 5'd1, 5'd17, CFG_W'($urandom_range(1, 16)),
                  CFG_W'($urandom_range(0, 31)), 5'd0, CFG_W'($urandom_range(1, 16))};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, no idling; slot zero should behave as slot one
    write_slot(5'd0);
    // bad message while still in init changes nothing
    send_event(make_item(1'b1, 1'b0, draw_time(), $urandom, draw_delay(), draw_delay()), 0);
    // beacon in init: adopt the carried counter, delay saturated, time at the top
    send_event(make_item(1'b1, 1'b1, '1, '1, '1, '0), 0);
    // beacon and bad message while waiting for the slot are both ignored
    send_event(make_item(1'b1, 1'b1, draw_time(), $urandom, '0, '1), 0);
    send_event(make_item(1'b1, 1'b0, '0, '0, '0, '0), 0);
    // slot timer with zero random delay, message fields set but unused
    send_event(make_item(1'b0, 1'b1, draw_time(), '1, '1, '0), 0);
    // bad message while waiting for a beacon
    send_event(make_item(1'b1, 1'b0, '1, '1, '1, '1), 0);
    // own beacon: frame counter wraps from all ones to zero
    send_event(make_item(1'b0, 1'b0, '0, '0, '0, '0), 0);
    // random delay far above the window is saturated
    send_event(make_item(1'b0, 1'b0, sb.last_deadline, '0, '0, '1), 0);
    // foreign beacon at time zero, counter zero, no delay
    send_event(make_item(1'b1, 1'b1, '0, '0, '0, '0), 0);
    send_event(make_item(1'b0, 1'b0, sb.last_deadline, '0, '0, MAX_DELAY_NS), 0);
    // delay just past the window edge, beacon a little early
    send_event(make_item(1'b1, 1'b1,
                         sb.frame_start + FRAME_NS + TIME_W'(MAX_DELAY_NS) - TIME_W'(5),
                         32'd1, MAX_DELAY_NS + 1'b1, '0), 0);
    send_event(make_item(1'b0, 1'b0, sb.last_deadline, '0, '0, MAX_DELAY_NS - 1'b1), 0);
    // beacon carrying a large counter at an arbitrary time
    send_event(make_item(1'b1, 1'b1, draw_time(), 32'h8000_0000, '0, '0), 0);
    send_event(make_item(1'b0, 1'b0, sb.last_deadline, '0, '0, draw_delay()), 0);
    // own beacon again, then a late foreign one
    send_event(make_item(1'b0, 1'b0, sb.last_deadline, '0, '0, '0), 0);
    send_event(make_item(1'b0, 1'b0, sb.last_deadline, '0, '0, draw_delay()), 0);
    send_event(make_item(1'b1, 1'b1, sb.frame_start + FRAME_NS + TIME_W'(30_000_000),
                         sb.frame_cnt + 1'b1, 25'd10_000_000, '0), 0);
    wait_drained();

    // random part: idling pattern and slot setting change per phase
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 58;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 58;
        end
        default: begin
          tx_idle_pct  = 7;
          rx_stall_pct = 7;
        end
      endcase
      write_slot(slot_plan[p]);
      for (int i = 0; i < PHASE_EVENTS; i++) send_event(next_event(), draw_gap());
      wait_drained();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tdma_beacon_slot_scheduler test passed");
    end else begin
      $display("tdma_beacon_slot_scheduler test failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("tdma_beacon_slot_scheduler test failed");
    $finish;
  end

endmodule
